[sv/cds_pkg.sv]
// Shared types, constants and tables for the calendar date stepper.
package cds_pkg;

  localparam int unsigned YEAR_BITS = 14;
  localparam int unsigned IN_W      = 40;
  localparam int unsigned OUT_W     = 32;

  // Divisibility by 25 through the modular inverse of 25 mod 2^14:
  // y is a multiple of 25 iff (y * INV25) mod 2^14 <= (2^14 - 1) / 25.
  localparam logic [YEAR_BITS-1:0] INV25     = 14'd7209;
  localparam logic [YEAR_BITS-1:0] DIV25_MAX = 14'd655;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [5:0] DAY_FIRST = 6'd1;
  localparam logic [5:0] DAY_LAST_DEC = 6'd31;

  typedef enum logic [1:0] {
    MODE_NEXT = 2'd0,
    MODE_PREV = 2'd1,
    MODE_ADD  = 2'd2,
    MODE_SUB  = 2'd3
  } mode_e;

  // Days before month m in a common year; month 0 adds nothing,
  // months past December add the whole year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] r;
    r = 9'd0;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd365;
    endcase
    return r;
  endfunction

  // Month length in a common year.
  function automatic logic [4:0] month_len_base(input logic [3:0] m);
    logic [4:0] r;
    r = 5'd31;
    case (m)
      4'd2:                  r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:               r = 5'd31;
    endcase
    return r;
  endfunction

  typedef struct packed {
    mode_e                mode;
    logic [5:0]           day;
    logic [3:0]           month;
    logic [YEAR_BITS-1:0] year;
    logic [8:0]           offset;
    logic [YEAR_BITS-1:0] prod;
    logic [8:0]           doy_base;
    logic                 m_feb;
    logic                 m_late;
    logic                 m_ok;
    logic [4:0]           len_base;
    logic [4:0]           prev_len_base;
    logic                 prev_feb;
  } s1_t;

  typedef struct packed {
    mode_e                mode;
    logic [8:0]           offset;
    logic                 valid;
    logic                 leap;
    logic [8:0]           doy;
    logic [5:0]           st_day;
    logic [3:0]           st_month;
    logic [YEAR_BITS-1:0] st_year;
  } s2_t;

  typedef struct packed {
    logic                 is_step;
    logic [5:0]           day;
    logic [3:0]           month;
    logic [YEAR_BITS-1:0] year;
    logic                 valid;
    logic                 leap;
    logic                 in_range;
    logic [8:0]           h;
    logic [3:0]           k;
  } s3_t;

  typedef struct packed {
    logic [5:0]           day;
    logic [3:0]           month;
    logic [YEAR_BITS-1:0] year;
    logic                 valid;
  } res_t;

endpackage

[sv/cds_dec.sv]
// Stage 1: month decode, day-of-year base and year residue product.
module cds_dec (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [1:0]                      mode_i,
  input  logic [5:0]                      day_i,
  input  logic [3:0]                      month_i,
  input  logic [cds_pkg::YEAR_BITS-1:0]   year_i,
  input  logic [8:0]                      offset_i,
  output logic                            valid_o,
  output cds_pkg::s1_t                    s1_o
);

  // Only the product mod 2^14 matters for the divisibility test.
  logic [cds_pkg::YEAR_BITS-1:0] prod;
  cds_pkg::s1_t s1_d, s1_q;
  logic v_q;

  assign prod = year_i * cds_pkg::INV25;

  always_comb begin
    s1_d.mode          = cds_pkg::mode_e'(mode_i);
    s1_d.day           = day_i;
    s1_d.month         = month_i;
    s1_d.year          = year_i;
    s1_d.offset        = offset_i;
    s1_d.prod          = prod;
    s1_d.doy_base      = 9'({3'd0, day_i} + cds_pkg::days_before(month_i));
    s1_d.m_feb         = (month_i == cds_pkg::MONTH_FEB);
    s1_d.m_late        = (month_i >= cds_pkg::MONTH_MAR);
    s1_d.m_ok          = (month_i >= cds_pkg::MONTH_JAN) && (month_i <= cds_pkg::MONTH_DEC);
    s1_d.len_base      = cds_pkg::month_len_base(month_i);
    s1_d.prev_len_base = cds_pkg::month_len_base(month_i - 4'd1);
    s1_d.prev_feb      = (month_i == cds_pkg::MONTH_MAR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = v_q;
  assign s1_o    = s1_q;

endmodule

[sv/cds_chk.sv]
// Stage 2: leap rule, date check, day of year and next/previous day.
module cds_chk (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cds_pkg::s1_t  s1_i,
  output logic          valid_o,
  output cds_pkg::s2_t  s2_o
);

  logic div25, leap, valid;
  logic [5:0] mlen, plen;
  cds_pkg::s2_t s2_d, s2_q;
  logic v_q;

  always_comb begin
    div25 = (s1_i.prod <= cds_pkg::DIV25_MAX);
    leap  = (s1_i.year[1:0] == 2'd0) && (!div25 || (s1_i.year[3:0] == 4'd0));
    mlen  = {1'b0, s1_i.len_base} + {5'd0, s1_i.m_feb && leap};
    plen  = {1'b0, s1_i.prev_len_base} + {5'd0, s1_i.prev_feb && leap};
    valid = (s1_i.year != '0) && s1_i.m_ok && (s1_i.day != 6'd0) && (s1_i.day <= mlen);

    s2_d.mode     = s1_i.mode;
    s2_d.offset   = s1_i.offset;
    s2_d.valid    = valid;
    s2_d.leap     = leap;
    s2_d.doy      = s1_i.doy_base + {8'd0, s1_i.m_late && leap};
    s2_d.st_day   = s1_i.day;
    s2_d.st_month = s1_i.month;
    s2_d.st_year  = s1_i.year;

    if (valid && (s1_i.mode == cds_pkg::MODE_NEXT)) begin
      if (s1_i.day == mlen) begin
        s2_d.st_day = cds_pkg::DAY_FIRST;
        if (s1_i.month == cds_pkg::MONTH_DEC) begin
          s2_d.st_month = cds_pkg::MONTH_JAN;
          s2_d.st_year  = s1_i.year + 1'b1;
        end else begin
          s2_d.st_month = s1_i.month + 4'd1;
        end
      end else begin
        s2_d.st_day = s1_i.day + 6'd1;
      end
    end else if (valid && (s1_i.mode == cds_pkg::MODE_PREV)) begin
      if (s1_i.day == cds_pkg::DAY_FIRST) begin
        if (s1_i.month == cds_pkg::MONTH_JAN) begin
          s2_d.st_month = cds_pkg::MONTH_DEC;
          s2_d.st_day   = cds_pkg::DAY_LAST_DEC;
          s2_d.st_year  = s1_i.year - 1'b1;
        end else begin
          s2_d.st_month = s1_i.month - 4'd1;
          s2_d.st_day   = plen;
        end
      end else begin
        s2_d.st_day = s1_i.day - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = v_q;
  assign s2_o    = s2_q;

endmodule

[sv/cds_map.sv]
// Stages 3 and 4: offset sum, month search, day recovery and result select.
module cds_map (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cds_pkg::s2_t  s2_i,
  output logic          valid_o,
  output cds_pkg::res_t res_o
);

  logic signed [10:0] h;
  logic [9:0]  len;
  logic [3:0]  k;
  logic [9:0]  pk;
  logic [8:0]  day_full;
  cds_pkg::s3_t  s3_d, s3_q;
  cds_pkg::res_t res_d, res_q;
  logic v3_q, v4_q;

  // Stage 3: h = doy +/- offset, month = 1 + count of month starts below h.
  always_comb begin
    len = s2_i.leap ? 10'd366 : 10'd365;
    if (s2_i.mode == cds_pkg::MODE_ADD) begin
      h = $signed({2'b00, s2_i.doy}) + $signed({2'b00, s2_i.offset});
    end else begin
      h = $signed({2'b00, s2_i.doy}) - $signed({2'b00, s2_i.offset});
    end
    k = cds_pkg::MONTH_JAN;
    for (int i = 2; i <= 12; i++) begin
      pk = {1'b0, cds_pkg::days_before(4'(i))} + {9'd0, s2_i.leap && (i >= 3)};
      if ({1'b0, pk} < h) begin
        k = k + 4'd1;
      end
    end
    s3_d.is_step  = (s2_i.mode == cds_pkg::MODE_NEXT) || (s2_i.mode == cds_pkg::MODE_PREV);
    s3_d.day      = s2_i.st_day;
    s3_d.month    = s2_i.st_month;
    s3_d.year     = s2_i.st_year;
    s3_d.valid    = s2_i.valid;
    s3_d.leap     = s2_i.leap;
    s3_d.in_range = !h[10] && (h != 11'sd0) && (h[9:0] <= len);
    s3_d.h        = h[8:0];
    s3_d.k        = k;
  end

  // Stage 4: day = h - start of the found month, then pick the result.
  always_comb begin
    day_full     = s3_q.h - cds_pkg::days_before(s3_q.k)
                   - {8'd0, s3_q.leap && (s3_q.k >= cds_pkg::MONTH_MAR)};
    res_d.day    = s3_q.day;
    res_d.month  = s3_q.month;
    res_d.year   = s3_q.year;
    res_d.valid  = s3_q.valid;
    if (!s3_q.is_step && s3_q.in_range) begin
      res_d.day   = day_full[5:0];
      res_d.month = s3_q.k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q  <= s3_d;
      res_q <= res_d;
    end
  end

  assign valid_o = v4_q;
  assign res_o   = res_q;

endmodule

[sv/calendar_date_step_core.sv]
// Top level of the Gregorian calendar date stepper.
//
// Input stream (s_axis): one transfer carries a date, a mode and an offset.
// Mode next/previous day steps a valid date and leaves an invalid one as is;
// mode add/subtract moves by the offset inside the date's own year and keeps
// the date when the sum leaves that year. The year wraps modulo 2^14.
// Output stream (m_axis): one transfer per input transfer, in order, with
// the result date and a flag telling whether the input date was valid.
//
// Throughput: one transfer per cycle unless m_axis stalls; the four register
// stages (decode, date check, month search, day recovery) each hold one item.
// The pipeline moves as one: it advances whenever the output register is
// empty or its result is being taken, so a stalled receiver freezes every
// stage in place and s_axis_tready drops; nothing is lost or repeated.
// Reset clears all stage valid bits; the block accepts input right after.
module calendar_date_step_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [1:0] mode, [7:2] day, [11:8] month, [25:12] year, [34:26] offset, rest zero
  input  logic [cds_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [5:0] res_day, [9:6] res_month, [23:10] res_year, [24] date_valid, rest zero
  output logic [cds_pkg::OUT_W-1:0]   m_axis_tdata
);

  logic          en;
  logic          v1, v2;
  cds_pkg::s1_t  s1;
  cds_pkg::s2_t  s2;
  cds_pkg::res_t res;

  // Whole pipeline steps together; output stage gates everything.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  cds_dec u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .mode_i   (s_axis_tdata[1:0]),
    .day_i    (s_axis_tdata[7:2]),
    .month_i  (s_axis_tdata[11:8]),
    .year_i   (s_axis_tdata[25:12]),
    .offset_i (s_axis_tdata[34:26]),
    .valid_o  (v1),
    .s1_o     (s1)
  );

  cds_chk u_chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .s1_i    (s1),
    .valid_o (v2),
    .s2_o    (s2)
  );

  cds_map u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2),
    .s2_i    (s2),
    .valid_o (m_axis_tvalid),
    .res_o   (res)
  );

  assign m_axis_tdata = {7'd0, res.valid, res.year, res.month, res.day};

  // A valid input date always yields a real calendar month.
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.valid) |-> (res.month >= 4'd1 && res.month <= 4'd12))
    else $error("result month out of range for a valid date");

  // ...and a day of month between 1 and 31.
  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.valid) |-> (res.day >= 6'd1 && res.day <= 6'd31))
    else $error("result day out of range for a valid date");

  // An accepted transfer lands in the first stage.
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted transfer lost at stage one");

  // A frozen pipeline keeps its stage-two item.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2 && !en) |=> v2)
    else $error("stage two item dropped during stall");

endmodule
